@@ rtl/ipit_pkg.sv @@
// types, command codes and register map for the io port interval timer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package ipit_pkg;

  // command codes carried in the cmd field
  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_READ   = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_PORT_A = 3'd3,
    CMD_PORT_B = 3'd4
  } cmd_e;

  // low two address bits for the port register group
  localparam logic [1:0] REG_DATA_A = 2'd0;
  localparam logic [1:0] REG_DIR_A  = 2'd1;
  localparam logic [1:0] REG_DATA_B = 2'd2;
  localparam logic [1:0] REG_DIR_B  = 2'd3;

  // address bit positions
  localparam int ADDR_SEL_BIT  = 0;  // timer vs status, edge polarity
  localparam int ADDR_GRP_BIT  = 2;  // ports vs timer group
  localparam int ADDR_LOAD_BIT = 4;  // timer load vs edge control

  localparam int PRESCALE_W = 11;
  localparam logic [7:0] READ_IDLE = 8'hFF;
  localparam logic [7:0] TIMER_WRAP = 8'hFF;
  localparam int PA7 = 7;

  // request beat
  typedef struct packed {
    logic [2:0] cmd;
    logic [4:0] address;
    logic [7:0] write_data;
    logic [7:0] set_bits;
    logic [7:0] clear_bits;
  } req_t;

  // response beat
  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] port_a_drive;
    logic [7:0] port_a_direction;
    logic [7:0] port_b_drive;
    logic [7:0] port_b_direction;
    logic       timer_expired;
    logic       edge_seen;
  } rsp_t;

  // prescale interval for a select code: 1, 8, 64, 1024
  function automatic logic [PRESCALE_W-1:0] interval_of(input logic [1:0] sel);
    logic [PRESCALE_W-1:0] r;
    case (sel)
      2'd0:    r = PRESCALE_W'(1);
      2'd1:    r = PRESCALE_W'(8);
      2'd2:    r = PRESCALE_W'(64);
      default: r = PRESCALE_W'(1024);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ipit_ports.sv @@
// port A/B latches, direction registers, external pins and PA7 edge detector
// depends on ipit_pkg
`timescale 1ns / 1ps
`default_nettype none

module ipit_ports (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire ipit_pkg::req_t item,
  output logic [7:0]         port_rd,
  output logic               edge_flag,
  output logic [7:0]         latch_a_next,
  output logic [7:0]         dir_a_next,
  output logic [7:0]         latch_b_next,
  output logic [7:0]         dir_b_next,
  output logic               edge_flag_next
);

  logic [7:0] dir_a, dir_b, latch_a, latch_b, pins_a, pins_b;
  logic [7:0] pins_a_next, pins_b_next;
  logic       edge_rising, edge_rising_next;
  logic [7:0] active;
  logic       target;

  // read value of the addressed port register
  always_comb begin
    case (item.address[1:0])
      ipit_pkg::REG_DATA_A: port_rd = (pins_a & ~dir_a) | (latch_a & dir_a);
      ipit_pkg::REG_DIR_A:  port_rd = dir_a;
      ipit_pkg::REG_DATA_B: port_rd = (pins_b & ~dir_b) | (latch_b & dir_b);
      default:              port_rd = dir_b;
    endcase
  end

  // polarity-selected pin bits for the edge detector
  assign active = edge_rising ? item.set_bits : item.clear_bits;
  assign target = edge_rising;

  // next state for one beat
  always_comb begin
    dir_a_next       = dir_a;
    dir_b_next       = dir_b;
    latch_a_next     = latch_a;
    latch_b_next     = latch_b;
    pins_a_next      = pins_a;
    pins_b_next      = pins_b;
    edge_flag_next   = edge_flag;
    edge_rising_next = edge_rising;
    case (item.cmd)
      ipit_pkg::CMD_READ: begin
        if (item.address[ipit_pkg::ADDR_GRP_BIT] && item.address[ipit_pkg::ADDR_SEL_BIT]) begin
          edge_flag_next = 1'b0;
        end
      end
      ipit_pkg::CMD_WRITE: begin
        if (!item.address[ipit_pkg::ADDR_GRP_BIT]) begin
          case (item.address[1:0])
            ipit_pkg::REG_DATA_A: latch_a_next = item.write_data;
            ipit_pkg::REG_DIR_A:  dir_a_next   = item.write_data;
            ipit_pkg::REG_DATA_B: latch_b_next = item.write_data;
            default:              dir_b_next   = item.write_data;
          endcase
        end else if (!item.address[ipit_pkg::ADDR_LOAD_BIT]) begin
          edge_rising_next = item.address[ipit_pkg::ADDR_SEL_BIT];
        end
      end
      ipit_pkg::CMD_PORT_A: begin
        // edge only counts while PA7 is an input and the pin actually moves
        if (!dir_a[ipit_pkg::PA7] && active[ipit_pkg::PA7] &&
            (pins_a[ipit_pkg::PA7] != target)) begin
          edge_flag_next = 1'b1;
        end
        pins_a_next = (pins_a & ~item.clear_bits) | item.set_bits;
      end
      ipit_pkg::CMD_PORT_B: begin
        pins_b_next = (pins_b & ~item.clear_bits) | item.set_bits;
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_a       <= '0;
      dir_b       <= '0;
      latch_a     <= '0;
      latch_b     <= '0;
      pins_a      <= '1;
      pins_b      <= '1;
      edge_flag   <= 1'b0;
      edge_rising <= 1'b0;
    end else if (en) begin
      dir_a       <= dir_a_next;
      dir_b       <= dir_b_next;
      latch_a     <= latch_a_next;
      latch_b     <= latch_b_next;
      pins_a      <= pins_a_next;
      pins_b      <= pins_b_next;
      edge_flag   <= edge_flag_next;
      edge_rising <= edge_rising_next;
    end
  end

  // edge flag rises only on a port A update
  a_edge_src: assert property (@(posedge clk) disable iff (rst)
    $rose(edge_flag) |-> $past(en && (item.cmd == ipit_pkg::CMD_PORT_A)))
    else $error("edge flag set by a beat other than a port A update");

  // an output PA7 never sets the edge flag
  a_edge_out: assert property (@(posedge clk) disable iff (rst)
    (en && !edge_flag && dir_a[ipit_pkg::PA7]) |=> !edge_flag)
    else $error("edge flag set while PA7 is an output");

endmodule

`default_nettype wire

@@ rtl/ipit_timer.sv @@
// interval timer: prescaler, down counter and underflow flag
// depends on ipit_pkg
`timescale 1ns / 1ps
`default_nettype none

module ipit_timer (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  wire ipit_pkg::req_t item,
  output logic [7:0]     timer_value,
  output logic           timer_flag,
  output logic           timer_flag_next
);

  logic [ipit_pkg::PRESCALE_W-1:0] prescale_count, prescale_count_next, count_inc;
  logic [1:0]                      prescale_select, prescale_select_next;
  logic [7:0]                      timer_value_next, value_dec;
  logic                            hit;

  // prescaler advance and underflow decision
  assign count_inc = prescale_count + ipit_pkg::PRESCALE_W'(1);
  assign hit       = (count_inc == ipit_pkg::interval_of(prescale_select)) || timer_flag;
  assign value_dec = timer_value - 8'd1;

  // next state for one beat
  always_comb begin
    timer_value_next     = timer_value;
    prescale_count_next  = prescale_count;
    prescale_select_next = prescale_select;
    timer_flag_next      = timer_flag;
    case (item.cmd)
      ipit_pkg::CMD_TICK: begin
        if (hit) begin
          prescale_count_next = '0;
          timer_value_next    = value_dec;
          if (value_dec == ipit_pkg::TIMER_WRAP) begin
            timer_flag_next = 1'b1;
          end
        end else begin
          prescale_count_next = count_inc;
        end
      end
      ipit_pkg::CMD_READ: begin
        // reading the count clears the flag
        if (item.address[ipit_pkg::ADDR_GRP_BIT] && !item.address[ipit_pkg::ADDR_SEL_BIT]) begin
          timer_flag_next = 1'b0;
        end
      end
      ipit_pkg::CMD_WRITE: begin
        if (item.address[ipit_pkg::ADDR_GRP_BIT] && item.address[ipit_pkg::ADDR_LOAD_BIT]) begin
          timer_value_next     = item.write_data - 8'd1;
          prescale_count_next  = '0;
          timer_flag_next      = 1'b0;
          prescale_select_next = item.address[1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_value     <= '0;
      prescale_count  <= '0;
      prescale_select <= 2'd3;
      timer_flag      <= 1'b0;
    end else if (en) begin
      timer_value     <= timer_value_next;
      prescale_count  <= prescale_count_next;
      prescale_select <= prescale_select_next;
      timer_flag      <= timer_flag_next;
    end
  end

  // underflow flag is only raised by a tick
  a_flag_src: assert property (@(posedge clk) disable iff (rst)
    $rose(timer_flag) |-> $past(en && (item.cmd == ipit_pkg::CMD_TICK)))
    else $error("timer flag set by a non-tick beat");

  // after underflow the prescaler is bypassed
  a_flag_fast: assert property (@(posedge clk) disable iff (rst)
    (en && timer_flag && (item.cmd == ipit_pkg::CMD_TICK)) |=> (prescale_count == '0))
    else $error("prescaler advanced while timer flag set");

endmodule

`default_nettype wire

@@ rtl/io_port_interval_timer.sv @@
// top level: input stage, port and timer units, result register
// depends on ipit_pkg, ipit_ports, ipit_timer
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  req     | req_valid / req_ready | ipit_pkg::req_t: one command beat
//  rsp     | rsp_valid / rsp_ready | ipit_pkg::rsp_t: one result per beat
//
// one beat per clock cycle sustained while rsp_ready is high; an accepted
// beat waits in the input stage, where the port and timer units update
// their state as it moves on into the result register, raising rsp_valid.
// reset (rst, synchronous) empties both stages and loads the register reset
// values. a stalled result holds the input stage; req_ready stays high while
// the input stage is empty or moving into the result register.
`timescale 1ns / 1ps
`default_nettype none

module io_port_interval_timer (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire ipit_pkg::req_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output ipit_pkg::rsp_t rsp
);

  logic           stg_valid;
  ipit_pkg::req_t stg_item;
  logic           advance;

  logic [7:0] port_rd;
  logic       edge_flag, edge_flag_next;
  logic [7:0] latch_a_next, dir_a_next, latch_b_next, dir_b_next;
  logic [7:0] timer_value;
  logic       timer_flag, timer_flag_next;
  logic [7:0] read_data;
  ipit_pkg::rsp_t rsp_next;

  // stage handshake
  assign advance   = stg_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !stg_valid || advance;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (req_ready) begin
      stg_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      stg_item <= req;
    end
  end

  ipit_ports u_ports (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .item           (stg_item),
    .port_rd        (port_rd),
    .edge_flag      (edge_flag),
    .latch_a_next   (latch_a_next),
    .dir_a_next     (dir_a_next),
    .latch_b_next   (latch_b_next),
    .dir_b_next     (dir_b_next),
    .edge_flag_next (edge_flag_next)
  );

  ipit_timer u_timer (
    .clk             (clk),
    .rst             (rst),
    .en              (advance),
    .item            (stg_item),
    .timer_value     (timer_value),
    .timer_flag      (timer_flag),
    .timer_flag_next (timer_flag_next)
  );

  // read data from the state before this beat
  always_comb begin
    read_data = ipit_pkg::READ_IDLE;
    if (stg_item.cmd == ipit_pkg::CMD_READ) begin
      if (!stg_item.address[ipit_pkg::ADDR_GRP_BIT]) begin
        read_data = port_rd;
      end else if (!stg_item.address[ipit_pkg::ADDR_SEL_BIT]) begin
        read_data = timer_value;
      end else begin
        read_data = {timer_flag, edge_flag, 6'b0};
      end
    end
  end

  // result beat
  always_comb begin
    rsp_next.read_data        = read_data;
    rsp_next.port_a_drive     = latch_a_next;
    rsp_next.port_a_direction = dir_a_next;
    rsp_next.port_b_drive     = latch_b_next;
    rsp_next.port_b_direction = dir_b_next;
    rsp_next.timer_expired    = timer_flag_next;
    rsp_next.edge_seen        = edge_flag_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  // a stalled result keeps a waiting beat in the input stage
  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    (stg_valid && rsp_valid && !rsp_ready) |=> stg_valid)
    else $error("input stage dropped a beat while result stalled");

  // every beat leaving the stage shows up as a result
  a_adv_rsp: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("beat advanced without a result");

  // no result appears without a beat behind it
  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(advance))
    else $error("result raised without an advancing beat");

endmodule

`default_nettype wire
